### rtl/core/kdq_pkg.sv
`default_nettype none

package kdq_pkg;

    // Opcodes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DELETE_ID  = 3'd4,
        OP_FIND_ID    = 3'd5,
        OP_READ_BACK  = 3'd6
    } op_t;

    // Result status codes
    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam int ID_BITS  = 16;
    localparam int LEN_BITS = 7;

    // What every cell of the chain does in a cycle
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD_AT,   // cell at the current count takes the new entry
        CMD_SHR,       // take left neighbor (cell 0 takes the new entry)
        CMD_SHL,       // take right neighbor
        CMD_ROT        // take right neighbor, tail cell takes the front entry
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Result bundle from the controller, payload travels beside it
    typedef struct packed {
        logic                valid;
        logic [1:0]          status;
        logic [ID_BITS-1:0]  id;
        logic [LEN_BITS-1:0] length;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/kdq_cell.sv
`default_nettype none

module kdq_cell
    import kdq_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32,
    parameter int INDEX        = 0
) (
    input  wire                           aclk,
    input  var cell_cmd_t                 cmd,
    input  wire  [$clog2(DEPTH+1)-1:0]    count,
    input  wire  [ID_BITS-1:0]            in_id,
    input  wire  [PAYLOAD_BITS-1:0]       in_pay,
    input  wire  [ID_BITS-1:0]            left_id,
    input  wire  [PAYLOAD_BITS-1:0]       left_pay,
    input  wire  [ID_BITS-1:0]            right_id,
    input  wire  [PAYLOAD_BITS-1:0]       right_pay,
    input  wire  [ID_BITS-1:0]            front_id,
    input  wire  [PAYLOAD_BITS-1:0]       front_pay,
    output logic [ID_BITS-1:0]            q_id,
    output logic [PAYLOAD_BITS-1:0]       q_pay
);

    localparam int CW = $clog2(DEPTH+1);

    logic [ID_BITS-1:0]      id_reg,  id_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic                    at_count, at_tail;

    assign at_count = (count == CW'(INDEX));
    assign at_tail  = (count == CW'(INDEX + 1));

    always_comb begin
        id_next  = id_reg;
        pay_next = pay_reg;
        case (cmd)
            CMD_LOAD_AT: begin
                if (at_count) begin
                    id_next  = in_id;
                    pay_next = in_pay;
                end
            end
            CMD_SHR: begin
                id_next  = left_id;
                pay_next = left_pay;
            end
            CMD_SHL: begin
                id_next  = right_id;
                pay_next = right_pay;
            end
            CMD_ROT: begin
                if (at_tail) begin
                    id_next  = front_id;
                    pay_next = front_pay;
                end else begin
                    id_next  = right_id;
                    pay_next = right_pay;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        pay_reg <= pay_next;
    end

    assign q_id  = id_reg;
    assign q_pay = pay_reg;

endmodule

`default_nettype wire

### rtl/core/kdq_ctrl.sv
`default_nettype none

module kdq_ctrl
    import kdq_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [2:0]                    in_op,
    input  wire  [ID_BITS-1:0]            in_id,
    input  wire  [ID_BITS-1:0]            front_id,
    input  wire  [PAYLOAD_BITS-1:0]       front_pay,
    input  wire                           res_take,
    output cell_cmd_t                     cmd,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output res_t                          res,
    output logic [PAYLOAD_BITS-1:0]       res_pay
);

    localparam int CW = $clog2(DEPTH+1);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rem_reg,   rem_next;
    op_t                     op_reg,    op_next;
    logic [ID_BITS-1:0]      key_reg,   key_next;
    logic                    found_reg, found_next;
    logic [ID_BITS-1:0]      cap_id_reg,  cap_id_next;
    logic [PAYLOAD_BITS-1:0] cap_pay_reg, cap_pay_next;
    res_t                    res_reg,   res_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;

    op_t  op_in;
    logic accept, empty, full, match, last;

    assign op_in    = op_t'(in_op);
    assign in_ready = (state_reg == S_IDLE) && (!res_reg.valid || res_take);
    assign accept   = in_valid && in_ready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign match    = (front_id == key_reg);
    assign last     = (rem_reg == CW'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && !empty &&
                    (op_in inside {OP_DELETE_ID, OP_FIND_ID, OP_READ_BACK})) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // cell commands and datapath
    always_comb begin
        cmd          = CMD_HOLD;
        count_next   = count_reg;
        rem_next     = rem_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        found_next   = found_reg;
        cap_id_next  = cap_id_reg;
        cap_pay_next = cap_pay_reg;
        res_next     = res_reg;
        res_pay_next = res_pay_reg;
        if (res_take) begin
            res_next.valid = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.valid  = 1'b1;
                    res_next.status = STAT_DONE;
                    res_next.id     = '0;
                    res_pay_next    = '0;
                    case (op_in)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            if (full) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                // front push into an empty chain lands in cell 0 too
                                cmd        = (op_in == OP_PUSH_BACK) ? CMD_LOAD_AT : CMD_SHR;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                res_next.status = STAT_MISS;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                res_next.status = STAT_MISS;
                            end else begin
                                cmd        = CMD_SHL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_DELETE_ID, OP_FIND_ID, OP_READ_BACK: begin
                            if (empty) begin
                                res_next.status = STAT_MISS;
                            end else begin
                                // result posted at the end of the scan
                                res_next.valid = 1'b0;
                                rem_next       = count_reg;
                                op_next        = op_in;
                                key_next       = in_id;
                                found_next     = 1'b0;
                                cap_id_next    = '0;
                                cap_pay_next   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    res_next.length = LEN_BITS'(count_next);
                end
            end
            S_SCAN: begin
                // front entry leaves; it is dropped on the first delete hit,
                // otherwise it re-enters at the tail
                if (op_reg == OP_DELETE_ID && !found_reg && match) begin
                    cmd        = CMD_SHL;
                    count_next = count_reg - CW'(1);
                    found_next = 1'b1;
                end else begin
                    cmd = CMD_ROT;
                    if ((op_reg == OP_FIND_ID && !found_reg && match) ||
                        (op_reg == OP_READ_BACK && last)) begin
                        cap_id_next  = front_id;
                        cap_pay_next = front_pay;
                        found_next   = 1'b1;
                    end
                end
                rem_next = rem_reg - CW'(1);
                if (last) begin
                    res_next.valid  = 1'b1;
                    res_next.status = found_next ? STAT_DONE : STAT_MISS;
                    res_next.id     = cap_id_next;
                    res_next.length = LEN_BITS'(count_next);
                    res_pay_next    = cap_pay_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        found_reg      <= found_next;
        cap_id_reg     <= cap_id_next;
        cap_pay_reg    <= cap_pay_next;
        res_pay_reg    <= res_pay_next;
    end

    assign count   = count_reg;
    assign res     = res_reg;
    assign res_pay = res_pay_reg;

endmodule

`default_nettype wire

### rtl/core/keyed_double_ended_queue.sv
`default_nettype none
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: opcode, item_id, item_payload
//  m_      | out | m_tvalid/m_tready  | m_tdata: status, entry_id_out,
//          |     |                    |          entry_payload_out, length
//
//  Push and pop transactions need no scan. Delete, find and read back scan all
//  N entries, N being the entry count: the cell chain rotates one position
//  per cycle until every entry has passed the front cell once.
//  aresetn (synchronous) clears the count, the control state and the output
//  valid; cell contents are not reset and no clearing pass is needed.
//  A result held on m_ while m_tready is low does not block the next input
//  transaction; a second finished result waits in the controller and stalls s_.

module keyed_double_ended_queue
    import kdq_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // s_tdata: opcode[3], item_id[16], item_payload[PAYLOAD_BITS], zero fill
    input  wire  [((3+ID_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // m_tdata: status[2], entry_id_out[16], entry_payload_out[PAYLOAD_BITS],
    //          length[7], zero fill
    output logic [((2+ID_BITS+PAYLOAD_BITS+LEN_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int CW    = $clog2(DEPTH+1);
    localparam int OUT_W = ((2+ID_BITS+PAYLOAD_BITS+LEN_BITS+7)/8)*8;
    localparam int ID_LO = 3;
    localparam int PL_LO = 3 + ID_BITS;

    // input field split
    logic [2:0]              in_op;
    logic [ID_BITS-1:0]      in_id;
    logic [PAYLOAD_BITS-1:0] in_pay;

    assign in_op  = s_tdata[2:0];
    assign in_id  = s_tdata[ID_LO +: ID_BITS];
    assign in_pay = s_tdata[PL_LO +: PAYLOAD_BITS];

    // chain and controller wiring
    cell_cmd_t               cmd;
    logic [CW-1:0]           count;
    res_t                    res;
    logic [PAYLOAD_BITS-1:0] res_pay;
    logic                    res_take;

    logic [ID_BITS-1:0]      cell_id  [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg,  m_data_next;

    assign res_take = !m_valid_reg || m_tready;

    kdq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_id     (in_id),
        .front_id  (cell_id[0]),
        .front_pay (cell_pay[0]),
        .res_take  (res_take),
        .cmd       (cmd),
        .count     (count),
        .res       (res),
        .res_pay   (res_pay)
    );

    // cell 0 is the front; its left neighbor is the incoming entry,
    // the last cell sees itself on the right
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_BITS-1:0]      l_id, r_id;
        logic [PAYLOAD_BITS-1:0] l_pay, r_pay;

        if (i == 0) begin : g_first
            assign l_id  = in_id;
            assign l_pay = in_pay;
        end else begin : g_mid_l
            assign l_id  = cell_id[i-1];
            assign l_pay = cell_pay[i-1];
        end

        if (i == DEPTH-1) begin : g_last
            assign r_id  = cell_id[i];
            assign r_pay = cell_pay[i];
        end else begin : g_mid_r
            assign r_id  = cell_id[i+1];
            assign r_pay = cell_pay[i+1];
        end

        kdq_cell #(
            .DEPTH        (DEPTH),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .INDEX        (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .count     (count),
            .in_id     (in_id),
            .in_pay    (in_pay),
            .left_id   (l_id),
            .left_pay  (l_pay),
            .right_id  (r_id),
            .right_pay (r_pay),
            .front_id  (cell_id[0]),
            .front_pay (cell_pay[0]),
            .q_id      (cell_id[i]),
            .q_pay     (cell_pay[i])
        );
    end

    // load a new result whenever the output slot is free or being drained
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_take) begin
            m_valid_next = res.valid;
            m_data_next  = OUT_W'({res.length, res_pay, res.id, res.status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // count never runs past the chain length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(DEPTH))
        else $error("entry count above depth");

    // accepted push into a store with room grows it by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && count != CW'(DEPTH) &&
         (in_op == OP_PUSH_BACK || in_op == OP_PUSH_FRONT))
        |=> (count == $past(count) + CW'(1)))
        else $error("push did not grow the count");

    // pop on an empty store leaves the count alone
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && count == '0 &&
         (in_op == OP_POP_BACK || in_op == OP_POP_FRONT))
        |=> (count == '0))
        else $error("pop on empty store changed the count");

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
    import kdq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int S_BITS = ((3 + ID_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_BITS = ((2 + ID_BITS + PAYLOAD_BITS + LEN_BITS + 7) / 8) * 8;

    // opcode 7 has no operation behind it; the block must leave the store alone
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // m_tdata field offsets, lowest first
    localparam int M_ID_LSB  = 2;
    localparam int M_PAY_LSB = M_ID_LSB + ID_BITS;
    localparam int M_LEN_LSB = M_PAY_LSB + PAYLOAD_BITS;

    typedef struct packed {
        logic [ID_BITS-1:0]      id;
        logic [PAYLOAD_BITS-1:0] payload;
    } stored_entry_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [ID_BITS-1:0]      id;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [LEN_BITS-1:0]     length;
    } queue_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;   // opcode[3], item_id[16], item_payload[32], zero fill
    logic              m_tvalid;
    logic              m_tready;
    logic [M_BITS-1:0] m_tdata;   // status[2], entry_id_out[16], entry_payload_out[32],
                                  // length[7], zero fill

    // Shadow copy of the ordered store, front at index 0
    stored_entry_t shadow_entries[$];
    // Results owed by the block, oldest first
    queue_result_t pending_results[$];

    int mismatch_count = 0;
    int tx_max_gap     = 11;  // sender gap drawn per transaction from 0..tx_max_gap
    int rx_max_stall   = 11;  // receiver stall drawn per transaction from 0..rx_max_stall
    int stall_left     = 0;
    int hold_cycles    = 0;   // long receiver hold-off, counted down by the receiver

    keyed_double_ended_queue #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction: apply one operation to the shadow store and queue
    // the result the block owes for it.
    // ---------------------------------------------------------------
    task automatic predict_queue_result(input logic [2:0] op, input logic [ID_BITS-1:0] id,
                                        input logic [PAYLOAD_BITS-1:0] payload);
        queue_result_t res;
        stored_entry_t ent;
        int            hit;
        res = '0;
        hit = -1;
        ent.id      = id;
        ent.payload = payload;
        // first match searching from the front
        for (int i = 0; i < shadow_entries.size(); i++) begin
            if (hit < 0 && shadow_entries[i].id == id)
                hit = i;
        end
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                // push into an empty store lands the same way from either end
                if (shadow_entries.size() >= DEPTH)
                    res.status = STAT_FULL;
                else if (op == OP_PUSH_BACK)
                    shadow_entries.push_back(ent);
                else
                    shadow_entries.push_front(ent);
            end
            OP_POP_BACK: begin
                if (shadow_entries.size() == 0)
                    res.status = STAT_MISS;
                else
                    void'(shadow_entries.pop_back());
            end
            OP_POP_FRONT: begin
                if (shadow_entries.size() == 0)
                    res.status = STAT_MISS;
                else
                    void'(shadow_entries.pop_front());
            end
            OP_DELETE_ID: begin
                if (hit < 0)
                    res.status = STAT_MISS;
                else
                    shadow_entries.delete(hit);
            end
            OP_FIND_ID: begin
                if (hit < 0) begin
                    res.status = STAT_MISS;
                end else begin
                    res.id      = shadow_entries[hit].id;
                    res.payload = shadow_entries[hit].payload;
                end
            end
            OP_READ_BACK: begin
                if (shadow_entries.size() == 0) begin
                    res.status = STAT_MISS;
                end else begin
                    res.id      = shadow_entries[$].id;
                    res.payload = shadow_entries[$].payload;
                end
            end
            default: ;  // unused opcode: store untouched, status done
        endcase
        res.length = LEN_BITS'(shadow_entries.size());
        pending_results.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Sender: one input transaction. Drives at the falling edge, looks
    // for the handshake at the rising edge. tvalid stays high when the
    // next transaction follows without a gap.
    // ---------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic [ID_BITS-1:0] id,
                             input logic [PAYLOAD_BITS-1:0] payload);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_BITS - 3 - ID_BITS - PAYLOAD_BITS){1'b0}}, payload, id, op};
        do @(posedge aclk); while (!s_tready);
        predict_queue_result(op, id, payload);
    endtask

    // Ids for random traffic: half are ones already stored (hits), some from a
    // tiny pool (duplicates), the rest anywhere in the 16-bit range.
    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && shadow_entries.size() > 0)
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].id;
        else if (r < 80)
            return ID_BITS'($urandom_range(0, 7));
        else
            return ID_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        case ($urandom_range(0, 4))
            0:       return OP_POP_BACK;
            1:       return OP_POP_FRONT;
            2:       return OP_DELETE_ID;
            3:       return OP_FIND_ID;
            default: return OP_READ_BACK;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: per-transaction stall, plus an occasional long hold-off.
    // ---------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin : check_results
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: m_tdata=%h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[M_ID_LSB +: ID_BITS] !== want.id) begin
                    $error("entry_id_out: expected %h, got %h",
                           want.id, m_tdata[M_ID_LSB +: ID_BITS]);
                    mismatch_count++;
                end
                if (m_tdata[M_PAY_LSB +: PAYLOAD_BITS] !== want.payload) begin
                    $error("entry_payload_out: expected %h, got %h",
                           want.payload, m_tdata[M_PAY_LSB +: PAYLOAD_BITS]);
                    mismatch_count++;
                end
                if (m_tdata[M_LEN_LSB +: LEN_BITS] !== want.length) begin
                    $error("length: expected %0d, got %0d",
                           want.length, m_tdata[M_LEN_LSB +: LEN_BITS]);
                    mismatch_count++;
                end
            end
            stall_left = $urandom_range(0, rx_max_stall);
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Empty-store misses, push front into empty, extreme ids/payloads,
    // duplicate ids (delete/find hit the front-most), absent ids, unused opcode.
    task automatic test_edge_cases();
        send_item(OP_POP_BACK,   16'h0000, 32'h0000_0000);
        send_item(OP_POP_FRONT,  16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_READ_BACK,  16'h0000, 32'h0000_0000);
        send_item(OP_FIND_ID,    16'h0000, 32'h0000_0000);
        send_item(OP_DELETE_ID,  16'h0000, 32'h0000_0000);
        send_item(OP_UNUSED,     16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PUSH_FRONT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PUSH_BACK,  16'h0000, 32'h0000_0000);
        send_item(OP_PUSH_FRONT, 16'h1234, 32'hA5A5_5A5A);
        send_item(OP_PUSH_BACK,  16'hFFFF, 32'h0000_0001);
        send_item(OP_FIND_ID,    16'hFFFF, 32'h0000_0000);
        send_item(OP_READ_BACK,  16'h0000, 32'h0000_0000);
        send_item(OP_DELETE_ID,  16'hFFFF, 32'h0000_0000);
        send_item(OP_FIND_ID,    16'hFFFF, 32'h0000_0000);
        send_item(OP_DELETE_ID,  16'h7777, 32'h0000_0000);
        send_item(OP_FIND_ID,    16'h8000, 32'h0000_0000);
        send_item(OP_UNUSED,     16'h1234, 32'h1234_5678);
        send_item(OP_POP_FRONT,  16'h0000, 32'h0000_0000);
        send_item(OP_FIND_ID,    16'h0000, 32'h0000_0000);
        send_item(OP_POP_BACK,   16'h0000, 32'h0000_0000);
        send_item(OP_READ_BACK,  16'h0000, 32'h0000_0000);
        send_item(OP_POP_BACK,   16'h0000, 32'h0000_0000);
        send_item(OP_READ_BACK,  16'h0000, 32'h0000_0000);
    endtask

    // Receiver holds off for a long stretch while the sender streams pushes
    // back to back: the block backs up and stalls s_, and the store goes
    // full so the last pushes are refused.
    task automatic test_fill_under_backpressure();
        tx_max_gap  = 0;
        hold_cycles = 400;
        repeat (80)
            send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      pick_id(), PAYLOAD_BITS'($urandom()));
        tx_max_gap = 11;
    endtask

    // Sender pauses until every result is back, then drains a full store
    // with pops, deletes, finds and back reads.
    task automatic test_drain_after_pause();
        logic [2:0] op;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        while (shadow_entries.size() > 0) begin
            op = pick_op(0);
            send_item(op, pick_id(), PAYLOAD_BITS'($urandom()));
        end
        send_item(OP_POP_FRONT, 16'h0000, 32'h0000_0000);
    endtask

    // Random traffic in blocks; each block picks a push bias and whether
    // either side idles, so the store swings between empty and full.
    task automatic test_random_traffic();
        int push_pct;
        for (int blk = 0; blk < 12; blk++) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 45;
            endcase
            tx_max_gap   = $urandom_range(0, 2) == 0 ? 0 : 11;
            rx_max_stall = $urandom_range(0, 2) == 0 ? 0 : 11;
            repeat (100)
                send_item(pick_op(push_pct), pick_id(), PAYLOAD_BITS'($urandom()));
        end
        tx_max_gap   = 11;
        rx_max_stall = 11;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_edge_cases();
        test_fill_under_backpressure();
        test_drain_after_pause();
        test_random_traffic();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // longest operation walks the whole chain once
        repeat (2 * DEPTH) @(posedge aclk);

        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
